// ----- design/arq_swc_pkg.sv -----
// shared types, codes and sizes for the arq sender window control block
// no dependencies; every other design file uses this package

package arq_swc_pkg;

  localparam int unsigned PendDepth = 32;
  localparam int unsigned SlotBits  = $clog2(PendDepth);
  localparam int unsigned SeqBits   = 16;
  localparam int unsigned WinBits   = 6;
  localparam int unsigned ApbAddrW  = 4;
  localparam int unsigned ApbDataW  = 32;

  localparam logic [WinBits-1:0] WinMax        = WinBits'(32);
  localparam logic [WinBits-1:0] WinResetVal   = WinBits'(8);
  localparam logic [3:0]         RetryResetVal = 4'd3;
  localparam logic [15:0]        TimeoutReset  = 16'd50;

  typedef logic [SlotBits-1:0] slot_idx_t;

  typedef enum logic [1:0] {
    ActSend = 2'd0,
    ActAck  = 2'd1,
    ActScan = 2'd2,
    ActGrow = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    KindSent       = 4'd0,
    KindRefWindow  = 4'd1,
    KindRefBusy    = 4'd2,
    KindAckMatch   = 4'd3,
    KindAckUnknown = 4'd4,
    KindRetransmit = 4'd5,
    KindGaveUp     = 4'd6,
    KindScanNone   = 4'd7,
    KindWinTick    = 4'd8
  } kind_e;

  typedef enum logic [1:0] {
    RegWindowLimit  = 2'd0,
    RegRetryLimit   = 2'd1,
    RegAckTimeout   = 2'd2,
    RegWindowEnable = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  dest_node;
    logic [15:0] ack_seq;
    logic [31:0] now_time;
  } in_beat_t;

  typedef struct packed {
    logic [3:0]         kind;
    logic [15:0]        seq_out;
    logic [7:0]         dest_out;
    logic [WinBits-1:0] window_now;
    logic [WinBits-1:0] in_flight_now;
    logic               last;
  } out_beat_t;

  typedef struct packed {
    logic [WinBits-1:0] window_limit;
    logic [3:0]         retry_limit;
    logic [15:0]        ack_timeout;
    logic               window_enable;
  } cfg_t;

  typedef struct packed {
    logic [SeqBits-1:0] seq;
    logic [7:0]         dest;
    logic [31:0]        sent_at;
    logic [3:0]         retries;
  } slot_t;

  typedef struct packed {
    logic      we;
    logic      set_v;
    logic      clr_v;
    slot_idx_t addr;
    slot_t     data;
  } tbl_wr_t;

  typedef struct packed {
    logic due;
    logic give_up;
  } chk_t;

endpackage

// ----- design/arq_swc_table.sv -----
// pending table: slot memory with registered read, plus per-slot valid flops
// depends on arq_swc_pkg

module arq_swc_table (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  arq_swc_pkg::tbl_wr_t                wr_i,
  input  arq_swc_pkg::slot_idx_t              rd_addr_i,
  output arq_swc_pkg::slot_t                  rd_data_o,
  output logic [arq_swc_pkg::PendDepth-1:0]   valid_o
);

  arq_swc_pkg::slot_t                mem [arq_swc_pkg::PendDepth];
  arq_swc_pkg::slot_t                rd_data_q;
  logic [arq_swc_pkg::PendDepth-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.set_v) begin
      valid_q[wr_i.addr] <= 1'b1;
    end else if (wr_i.clr_v) begin
      valid_q[wr_i.addr] <= 1'b0;
    end
  end

  assign rd_data_o = rd_data_q;
  assign valid_o   = valid_q;

endmodule

// ----- design/arq_swc_age_unit.sv -----
// check unit: entry age against the ack timeout, retries against the limit
// depends on arq_swc_pkg

module arq_swc_age_unit (
  input  logic [31:0]        now_i,
  input  arq_swc_pkg::slot_t entry_i,
  input  arq_swc_pkg::cfg_t  cfg_i,
  output arq_swc_pkg::chk_t  chk_o
);

  logic [31:0] age;

  assign age           = now_i - entry_i.sent_at;
  assign chk_o.due     = (age >= {16'd0, cfg_i.ack_timeout});
  assign chk_o.give_up = (entry_i.retries >= cfg_i.retry_limit);

endmodule

// ----- design/arq_swc_ctrl.sv -----
// sequencer: send, ack, scan and grow handling, window state and output register
// depends on arq_swc_pkg, arq_swc_age_unit

module arq_swc_ctrl (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  arq_swc_pkg::cfg_t                       cfg_i,
  input  logic                                    win_load_i,
  input  logic [arq_swc_pkg::WinBits-1:0]         win_load_val_i,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  arq_swc_pkg::in_beat_t                   in_data_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output arq_swc_pkg::out_beat_t                  out_data_o,
  output arq_swc_pkg::tbl_wr_t                    tbl_wr_o,
  output arq_swc_pkg::slot_idx_t                  rd_addr_o,
  input  arq_swc_pkg::slot_t                      rd_data_i,
  input  logic [arq_swc_pkg::PendDepth-1:0]       valid_i
);

  typedef enum logic [2:0] {
    StIdle,
    StSend,
    StAck,
    StScan,
    StScanEnd,
    StGrow
  } state_e;

  state_e                               state_q, state_d;
  arq_swc_pkg::in_beat_t                item_q, item_d;
  arq_swc_pkg::slot_idx_t               idx_q, idx_d;
  logic [arq_swc_pkg::SeqBits-1:0]      cnt_q, cnt_d;
  logic [arq_swc_pkg::WinBits-1:0]      win_q, win_d;
  logic [arq_swc_pkg::WinBits-1:0]      infl_q, infl_d;
  logic                                 hold_v_q, hold_v_d;
  arq_swc_pkg::out_beat_t               hold_q, hold_d;
  logic                                 out_valid_q, out_valid_d;
  arq_swc_pkg::out_beat_t               out_q, out_d;

  logic                                 out_free;
  logic [arq_swc_pkg::SeqBits-1:0]      nxt_seq;
  arq_swc_pkg::slot_idx_t               nxt_slot;
  arq_swc_pkg::slot_idx_t               ack_slot;
  arq_swc_pkg::slot_idx_t               scan_start;
  arq_swc_pkg::slot_idx_t               cur_slot;
  arq_swc_pkg::chk_t                    chk;
  logic                                 due;
  logic                                 commit;
  logic                                 matched;
  arq_swc_pkg::out_beat_t               res;
  arq_swc_pkg::slot_t                   wr_entry;

  arq_swc_age_unit u_age (
    .now_i   (item_q.now_time),
    .entry_i (rd_data_i),
    .cfg_i   (cfg_i),
    .chk_o   (chk)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign nxt_seq    = arq_swc_pkg::SeqBits'(cnt_q + arq_swc_pkg::SeqBits'(1));
  assign nxt_slot   = nxt_seq[arq_swc_pkg::SlotBits-1:0];
  assign ack_slot   = item_q.ack_seq[arq_swc_pkg::SlotBits-1:0];
  // scan starts right after the counter (oldest pending seq) once the counter reached PendDepth-1, else at slot 0
  assign scan_start = (cnt_q >= arq_swc_pkg::SeqBits'(arq_swc_pkg::PendDepth - 1))
                      ? nxt_slot : '0;
  assign cur_slot   = arq_swc_pkg::slot_idx_t'(scan_start + idx_q);
  assign due        = valid_i[cur_slot] && chk.due;
  assign commit     = !due || !hold_v_q || out_free;
  assign matched    = valid_i[ack_slot] &&
                      (rd_data_i.seq == item_q.ack_seq[arq_swc_pkg::SeqBits-1:0]);

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    win_d       = win_q;
    infl_d      = infl_q;
    hold_v_d    = hold_v_q;
    hold_d      = hold_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    tbl_wr_o    = '0;
    res         = '0;
    wr_entry    = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (win_load_i) begin
      win_d = win_load_val_i;
    end

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          item_d = in_data_i;
          idx_d  = '0;
          unique case (in_data_i.action)
            arq_swc_pkg::ActSend: state_d = StSend;
            arq_swc_pkg::ActAck:  state_d = StAck;
            arq_swc_pkg::ActScan: state_d = StScan;
            default:              state_d = StGrow;
          endcase
        end
      end

      StSend: begin
        if (out_free) begin
          res.last          = 1'b1;
          res.window_now    = win_q;
          res.in_flight_now = infl_q;
          if (cfg_i.window_enable && (infl_q >= win_q)) begin
            res.kind = arq_swc_pkg::KindRefWindow;
          end else if (valid_i[nxt_slot]) begin
            res.kind = arq_swc_pkg::KindRefBusy;
          end else begin
            wr_entry.seq      = nxt_seq;
            wr_entry.dest     = item_q.dest_node;
            wr_entry.sent_at  = item_q.now_time;
            wr_entry.retries  = 4'd0;
            tbl_wr_o.we       = 1'b1;
            tbl_wr_o.set_v    = 1'b1;
            tbl_wr_o.addr     = nxt_slot;
            tbl_wr_o.data     = wr_entry;
            cnt_d             = nxt_seq;
            infl_d            = arq_swc_pkg::WinBits'(infl_q + arq_swc_pkg::WinBits'(1));
            res.kind          = arq_swc_pkg::KindSent;
            res.seq_out       = nxt_seq;
            res.dest_out      = item_q.dest_node;
            res.in_flight_now = infl_d;
          end
          out_valid_d = 1'b1;
          out_d       = res;
          state_d     = StIdle;
        end
      end

      StAck: begin
        if (out_free) begin
          res.last    = 1'b1;
          res.seq_out = item_q.ack_seq;
          if (matched) begin
            tbl_wr_o.clr_v = 1'b1;
            tbl_wr_o.addr  = ack_slot;
            if (infl_q != '0) begin
              infl_d = arq_swc_pkg::WinBits'(infl_q - arq_swc_pkg::WinBits'(1));
            end
            if (cfg_i.window_enable && (win_q < cfg_i.window_limit)) begin
              win_d = arq_swc_pkg::WinBits'(win_q + arq_swc_pkg::WinBits'(1));
            end
            res.kind     = arq_swc_pkg::KindAckMatch;
            res.dest_out = rd_data_i.dest;
          end else begin
            res.kind = arq_swc_pkg::KindAckUnknown;
          end
          res.window_now    = win_d;
          res.in_flight_now = infl_d;
          out_valid_d       = 1'b1;
          out_d             = res;
          state_d           = StIdle;
        end
      end

      StScan: begin
        if (due && commit) begin
          if (hold_v_q) begin
            out_valid_d = 1'b1;
            out_d       = hold_q;
          end
          if (chk.give_up) begin
            tbl_wr_o.clr_v = 1'b1;
            tbl_wr_o.addr  = cur_slot;
            if (infl_q != '0) begin
              infl_d = arq_swc_pkg::WinBits'(infl_q - arq_swc_pkg::WinBits'(1));
            end
            res.kind = arq_swc_pkg::KindGaveUp;
          end else begin
            wr_entry         = rd_data_i;
            wr_entry.sent_at = item_q.now_time;
            wr_entry.retries = 4'(rd_data_i.retries + 4'd1);
            tbl_wr_o.we      = 1'b1;
            tbl_wr_o.addr    = cur_slot;
            tbl_wr_o.data    = wr_entry;
            if (cfg_i.window_enable && (win_q > arq_swc_pkg::WinBits'(1))) begin
              win_d = arq_swc_pkg::WinBits'(win_q - arq_swc_pkg::WinBits'(1));
            end
            res.kind = arq_swc_pkg::KindRetransmit;
          end
          res.seq_out       = rd_data_i.seq;
          res.dest_out      = rd_data_i.dest;
          res.window_now    = win_d;
          res.in_flight_now = infl_d;
          hold_d            = res;
          hold_v_d          = 1'b1;
        end
        if (commit) begin
          if (idx_q == arq_swc_pkg::slot_idx_t'(arq_swc_pkg::PendDepth - 1)) begin
            state_d = StScanEnd;
          end else begin
            idx_d = arq_swc_pkg::slot_idx_t'(idx_q + 1'b1);
          end
        end
      end

      StScanEnd: begin
        if (out_free) begin
          if (hold_v_q) begin
            res      = hold_q;
            res.last = 1'b1;
          end else begin
            res.kind          = arq_swc_pkg::KindScanNone;
            res.window_now    = win_q;
            res.in_flight_now = infl_q;
            res.last          = 1'b1;
          end
          hold_v_d    = 1'b0;
          out_valid_d = 1'b1;
          out_d       = res;
          state_d     = StIdle;
        end
      end

      StGrow: begin
        if (out_free) begin
          if (cfg_i.window_enable && (win_q < cfg_i.window_limit)) begin
            win_d = arq_swc_pkg::WinBits'(win_q + arq_swc_pkg::WinBits'(1));
          end
          res.kind          = arq_swc_pkg::KindWinTick;
          res.window_now    = win_d;
          res.in_flight_now = infl_q;
          res.last          = 1'b1;
          out_valid_d       = 1'b1;
          out_d             = res;
          state_d           = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase

    if (state_q == StIdle) begin
      rd_addr_o = (in_data_i.action == arq_swc_pkg::ActAck)
                  ? in_data_i.ack_seq[arq_swc_pkg::SlotBits-1:0] : scan_start;
    end else if (state_q == StAck) begin
      rd_addr_o = ack_slot;
    end else begin
      rd_addr_o = arq_swc_pkg::slot_idx_t'(scan_start + idx_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      cnt_q       <= '0;
      win_q       <= arq_swc_pkg::WinResetVal;
      infl_q      <= '0;
      hold_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      win_q       <= win_d;
      infl_q      <= infl_d;
      hold_v_q    <= hold_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    hold_q <= hold_d;
    out_q  <= out_d;
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- design/arq_sender_window_control.sv -----
// top level: apb register file, sequencer and pending table of the arq sender
// send, ack and grow: one result beat, registered from the handling state once the output register is free
// scan: one pending slot per cycle unless a due slot waits on the output register, results in seq order
// one item at a time; the next item is taken once the last beat is in the output register
// reset: table valid bits, counters and output cleared at once, registers at reset values
// depends on arq_swc_pkg, arq_swc_ctrl, arq_swc_table

module arq_sender_window_control (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [arq_swc_pkg::ApbAddrW-1:0]     paddr,
  input  logic [arq_swc_pkg::ApbDataW-1:0]     pwdata,
  output logic [arq_swc_pkg::ApbDataW-1:0]     prdata,
  output logic                                 pready,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  arq_swc_pkg::in_beat_t                in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output arq_swc_pkg::out_beat_t               out_data_o
);

  arq_swc_pkg::cfg_t                   cfg_q, cfg_d;
  arq_swc_pkg::cfg_reg_e               reg_sel;
  logic                                wr_en;
  logic                                win_load;
  logic [arq_swc_pkg::WinBits-1:0]     win_raw;
  logic [arq_swc_pkg::WinBits-1:0]     win_clamped;
  arq_swc_pkg::tbl_wr_t                tbl_wr;
  arq_swc_pkg::slot_idx_t              rd_addr;
  arq_swc_pkg::slot_t                  rd_data;
  logic [arq_swc_pkg::PendDepth-1:0]   slot_valid;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = arq_swc_pkg::cfg_reg_e'(paddr[3:2]);
  assign win_raw = pwdata[arq_swc_pkg::WinBits-1:0];

  always_comb begin
    if (win_raw == '0) begin
      win_clamped = arq_swc_pkg::WinBits'(1);
    end else if (win_raw > arq_swc_pkg::WinMax) begin
      win_clamped = arq_swc_pkg::WinMax;
    end else begin
      win_clamped = win_raw;
    end
  end

  always_comb begin
    cfg_d    = cfg_q;
    win_load = 1'b0;
    if (wr_en) begin
      unique case (reg_sel)
        arq_swc_pkg::RegWindowLimit: begin
          cfg_d.window_limit = win_clamped;
          win_load           = 1'b1;
        end
        arq_swc_pkg::RegRetryLimit:  cfg_d.retry_limit   = pwdata[3:0];
        arq_swc_pkg::RegAckTimeout:  cfg_d.ack_timeout   = pwdata[15:0];
        arq_swc_pkg::RegWindowEnable: cfg_d.window_enable = pwdata[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      arq_swc_pkg::RegWindowLimit:
        prdata = {{(arq_swc_pkg::ApbDataW - arq_swc_pkg::WinBits){1'b0}}, cfg_q.window_limit};
      arq_swc_pkg::RegRetryLimit:   prdata = {28'd0, cfg_q.retry_limit};
      arq_swc_pkg::RegAckTimeout:   prdata = {16'd0, cfg_q.ack_timeout};
      arq_swc_pkg::RegWindowEnable: prdata = {31'd0, cfg_q.window_enable};
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_limit  <= arq_swc_pkg::WinResetVal;
      cfg_q.retry_limit   <= arq_swc_pkg::RetryResetVal;
      cfg_q.ack_timeout   <= arq_swc_pkg::TimeoutReset;
      cfg_q.window_enable <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  arq_swc_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (tbl_wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .valid_o   (slot_valid)
  );

  arq_swc_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .win_load_i     (win_load),
    .win_load_val_i (win_clamped),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_data_i      (in_data_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_data_o     (out_data_o),
    .tbl_wr_o       (tbl_wr),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data),
    .valid_i        (slot_valid)
  );

endmodule
